@@ rtl/ntwa_pkg.sv @@
// Shared types and constants for the neighbor table with aging.
`default_nettype none
package ntwa_pkg;

	localparam logic [15:0] OWN_ID_RESET    = 16'd43707;
	localparam logic [10:0] AGE_LIMIT_RESET = 11'd1600;
	localparam logic [15:0] WRAP_LOW        = 16'd500;
	localparam logic [15:0] WRAP_HIGH       = 16'd65000;
	localparam logic [3:0]  CLEARED_MAX     = 4'd15;

	localparam logic [1:0] MODE_REPORT = 2'd0;
	localparam logic [1:0] MODE_TICK   = 2'd1;
	localparam logic [1:0] MODE_READ   = 2'd2;

	localparam logic [1:0] OP_REPORT = 2'd0;
	localparam logic [1:0] OP_TICK   = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;
	localparam logic [1:0] OP_NONE   = 2'd3;

	localparam logic CFG_OWN_ID    = 1'b0;
	localparam logic CFG_AGE_LIMIT = 1'b1;

	typedef struct packed {
		logic [1:0]         op;
		logic [15:0]        id;
		logic signed [15:0] temp;
		logic [15:0]        seq;
		logic               origin;
		logic [3:0]         read_slot;
	} cmd_t;

	typedef struct packed {
		logic [15:0]        id;
		logic signed [15:0] temp;
		logic [15:0]        seq;
		logic [10:0]        age;
	} rec_t;

	typedef struct packed {
		logic        write;
		logic        index;
		logic [15:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic [3:0]         slot_used;
		logic               accepted;
		logic               fresh_from_sender;
		logic [3:0]         cleared_count;
		logic [15:0]        out_id;
		logic signed [15:0] out_temp;
		logic [15:0]        out_seq;
	} res_t;

	function automatic logic newer(input logic [15:0] fresh, input logic [15:0] stored);
		newer = (fresh > stored) || ((fresh < WRAP_LOW) && (stored > WRAP_HIGH));
	endfunction

endpackage
`default_nettype wire

@@ rtl/ntwa_front.sv @@
// Front end: accept input beats and classify them into table commands.
`default_nettype none
module ntwa_front #(
	parameter int TABLE_SLOTS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         mode,
	input  wire logic [15:0]        record_id,
	input  wire logic signed [15:0] record_temp,
	input  wire logic [15:0]        record_seq,
	input  wire logic               sender_is_origin,
	input  wire logic [3:0]         read_slot,
	output logic                    push,
	output ntwa_pkg::cmd_t          push_cmd,
	input  wire logic               q_full
);

	logic           cmd_valid_s1;
	ntwa_pkg::cmd_t cmd_s1;
	ntwa_pkg::cmd_t cmd_d;
	logic           accept;

	assign in_stall = cmd_valid_s1 && q_full;
	assign accept   = in_valid && !in_stall;
	assign push     = cmd_valid_s1 && !q_full;
	assign push_cmd = cmd_s1;

	always_comb begin
		cmd_d.id        = record_id;
		cmd_d.temp      = record_temp;
		cmd_d.seq       = record_seq;
		cmd_d.origin    = sender_is_origin;
		cmd_d.read_slot = read_slot;
		case (mode)
			ntwa_pkg::MODE_REPORT: cmd_d.op = ntwa_pkg::OP_REPORT;
			ntwa_pkg::MODE_TICK:   cmd_d.op = ntwa_pkg::OP_TICK;
			ntwa_pkg::MODE_READ: begin
				if (32'(read_slot) < TABLE_SLOTS)
					cmd_d.op = ntwa_pkg::OP_READ;
				else
					cmd_d.op = ntwa_pkg::OP_NONE;
			end
			default: cmd_d.op = ntwa_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (accept) begin
			cmd_valid_s1 <= 1'b1;
		end else if (push) begin
			cmd_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			cmd_s1 <= cmd_d;
	end

endmodule
`default_nettype wire

@@ rtl/ntwa_queue.sv @@
// Two-entry command queue between front end and table engine.
`default_nettype none
module ntwa_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire ntwa_pkg::cmd_t push_cmd,
	output logic                full,
	input  wire logic           pop,
	output ntwa_pkg::cmd_t      pop_cmd,
	output logic                empty
);

	ntwa_pkg::cmd_t buf_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign pop_cmd = buf_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			buf_q[wr_ptr_q] <= push_cmd;
	end

endmodule
`default_nettype wire

@@ rtl/ntwa_back.sv @@
// Table engine: slot memory, scan sequencer and result register.
`default_nettype none
module ntwa_back #(
	parameter int TABLE_SLOTS = 16
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire ntwa_pkg::cfg_wr_t cfg,
	input  wire logic            q_empty,
	input  wire ntwa_pkg::cmd_t  q_cmd,
	output logic                 pop,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output ntwa_pkg::res_t       res
);

	localparam int IW = $clog2(TABLE_SLOTS);
	localparam int CW = $clog2(TABLE_SLOTS + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RPT  = 3'd1;
	localparam logic [2:0] ST_TICK = 3'd2;
	localparam logic [2:0] ST_RD   = 3'd3;
	localparam logic [2:0] ST_RDW  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	ntwa_pkg::rec_t mem [TABLE_SLOTS];
	ntwa_pkg::rec_t rdata_s1;
	logic [TABLE_SLOTS-1:0] vld_q;
	logic           rvld_s1;

	logic [2:0]     state_q;
	ntwa_pkg::cmd_t cmd_q;
	logic [CW-1:0]  n_q;
	logic [CW-1:0]  iss_q;
	logic           chk_s1;
	logic [IW-1:0]  chk_idx_s1;
	logic [15:0]    slot0_id_q;
	logic [10:0]    age_limit_q;
	ntwa_pkg::res_t res_q;
	ntwa_pkg::res_t out_q;
	logic           out_valid_q;

	ntwa_pkg::rec_t entry;
	logic [15:0]    eid;
	logic           issue_ok;
	logic           rd_en;
	logic [IW-1:0]  rd_addr;
	logic           wr_en;
	logic [IW-1:0]  wr_addr;
	ntwa_pkg::rec_t wr_data;
	logic           hit;
	logic           scan_done;
	logic           alloc_ok;
	logic           take;
	logic [IW-1:0]  s_sel;
	logic           out_free;
	logic           aged_out;

	assign entry     = rvld_s1 ? rdata_s1 : '0;
	assign eid       = (chk_idx_s1 == '0) ? slot0_id_q : entry.id;
	assign issue_ok  = (iss_q < n_q);
	assign scan_done = !chk_s1 && !issue_ok;
	assign alloc_ok  = (n_q < CW'(TABLE_SLOTS));
	assign hit       = chk_s1 && ((eid == cmd_q.id) || (eid == 16'd0));
	assign aged_out  = (entry.age >= age_limit_q);
	assign out_free  = !out_valid_q || !out_stall;
	assign pop       = (state_q == ST_IDLE) && !q_empty;
	assign out_valid = out_valid_q;
	assign res       = out_q;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = iss_q[IW-1:0];
		wr_en   = 1'b0;
		wr_addr = chk_idx_s1;
		wr_data = entry;
		take    = 1'b0;
		s_sel   = chk_idx_s1;
		case (state_q)
			ST_RPT: begin
				rd_en = issue_ok && !hit;
				if (hit) begin
					take = cmd_q.origin || ((chk_idx_s1 != '0)
						&& ntwa_pkg::newer(cmd_q.seq, entry.seq));
				end else if (scan_done && alloc_ok) begin
					s_sel = n_q[IW-1:0];
					take  = cmd_q.origin || ntwa_pkg::newer(cmd_q.seq, 16'd0);
				end
				wr_en   = take;
				wr_addr = s_sel;
				wr_data = '{id: cmd_q.id, temp: cmd_q.temp, seq: cmd_q.seq, age: 11'd0};
			end
			ST_TICK: begin
				rd_en = issue_ok;
				wr_en = chk_s1;
				if (aged_out)
					wr_data = '{id: 16'd0, temp: entry.temp, seq: 16'd0, age: 11'd0};
				else
					wr_data.age = entry.age + 11'd1;
			end
			ST_RD: begin
				rd_en   = 1'b1;
				rd_addr = IW'(cmd_q.read_slot);
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rdata_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_q         <= CW'(1);
			iss_q       <= '0;
			chk_s1      <= 1'b0;
			chk_idx_s1  <= '0;
			vld_q       <= '0;
			rvld_s1     <= 1'b0;
			slot0_id_q  <= ntwa_pkg::OWN_ID_RESET;
			age_limit_q <= ntwa_pkg::AGE_LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.write && cfg.index == ntwa_pkg::CFG_OWN_ID)
				slot0_id_q <= cfg.data;
			else if (wr_en && wr_addr == '0)
				slot0_id_q <= wr_data.id;
			if (cfg.write && cfg.index == ntwa_pkg::CFG_AGE_LIMIT)
				age_limit_q <= cfg.data[10:0];
			if (wr_en)
				vld_q[wr_addr] <= 1'b1;
			if (rd_en) begin
				rvld_s1    <= vld_q[rd_addr];
				chk_idx_s1 <= rd_addr;
			end
			chk_s1 <= rd_en && ((state_q == ST_RPT) || (state_q == ST_TICK));
			if (rd_en)
				iss_q <= iss_q + CW'(1);
			if (state_q == ST_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						case (q_cmd.op)
							ntwa_pkg::OP_REPORT: begin
								iss_q   <= '0;
								state_q <= ST_RPT;
							end
							ntwa_pkg::OP_TICK: begin
								iss_q   <= CW'(1);
								state_q <= ST_TICK;
							end
							ntwa_pkg::OP_READ: state_q <= ST_RD;
							default:           state_q <= ST_FIN;
						endcase
					end
				end
				ST_RPT: begin
					if (hit) begin
						state_q <= ST_FIN;
					end else if (scan_done) begin
						if (alloc_ok)
							n_q <= n_q + CW'(1);
						state_q <= ST_FIN;
					end
				end
				ST_TICK: begin
					if (scan_done)
						state_q <= ST_FIN;
				end
				ST_RD:  state_q <= ST_RDW;
				ST_RDW: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop)
					res_q <= '0;
			end
			ST_RPT: begin
				if (hit || scan_done) begin
					res_q.slot_used         <= (hit || alloc_ok) ? 4'(s_sel) : 4'd0;
					res_q.accepted          <= take;
					res_q.fresh_from_sender <= take && cmd_q.origin;
				end
			end
			ST_TICK: begin
				if (chk_s1 && aged_out && res_q.cleared_count != ntwa_pkg::CLEARED_MAX)
					res_q.cleared_count <= res_q.cleared_count + 4'd1;
			end
			ST_RDW: begin
				res_q.out_id   <= eid;
				res_q.out_temp <= entry.temp;
				res_q.out_seq  <= entry.seq;
			end
			default: begin
				res_q <= res_q;
			end
		endcase
		if (state_q == ST_FIN && out_free)
			out_q <= res_q;
	end

	always_ff @(posedge clk) begin
		if (pop)
			cmd_q <= q_cmd;
	end

endmodule
`default_nettype wire

@@ rtl/neighbor_table_with_aging.sv @@
// The report scan stops at the first hit; mode 3 or a bad read slot gives a result with no table access.
// One item in the engine at a time; a front register and a two-entry queue take beats meanwhile.
// Reset clears the slot valid bits at once; a beat is taken in the first cycle after release.
// Top level: neighbor table with aging.
`default_nettype none
module neighbor_table_with_aging #(
	parameter int TABLE_SLOTS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_write,
	input  wire logic               cfg_index,
	input  wire logic [15:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         mode,
	input  wire logic [15:0]        record_id,
	input  wire logic signed [15:0] record_temp,
	input  wire logic [15:0]        record_seq,
	input  wire logic               sender_is_origin,
	input  wire logic [3:0]         read_slot,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [3:0]              slot_used,
	output logic                    accepted,
	output logic                    fresh_from_sender,
	output logic [3:0]              cleared_count,
	output logic [15:0]             out_id,
	output logic signed [15:0]      out_temp,
	output logic [15:0]             out_seq
);

	logic              push;
	ntwa_pkg::cmd_t    push_cmd;
	logic              q_full;
	logic              pop;
	ntwa_pkg::cmd_t    pop_cmd;
	logic              q_empty;
	ntwa_pkg::cfg_wr_t cfg;
	ntwa_pkg::res_t    res;

	assign cfg = '{write: cfg_write, index: cfg_index, data: cfg_data};

	ntwa_front #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.mode             (mode),
		.record_id        (record_id),
		.record_temp      (record_temp),
		.record_seq       (record_seq),
		.sender_is_origin (sender_is_origin),
		.read_slot        (read_slot),
		.push             (push),
		.push_cmd         (push_cmd),
		.q_full           (q_full)
	);

	ntwa_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.empty    (q_empty)
	);

	ntwa_back #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_empty   (q_empty),
		.q_cmd     (pop_cmd),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	assign slot_used         = res.slot_used;
	assign accepted          = res.accepted;
	assign fresh_from_sender = res.fresh_from_sender;
	assign cleared_count     = res.cleared_count;
	assign out_id            = res.out_id;
	assign out_temp          = res.out_temp;
	assign out_seq           = res.out_seq;

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the neighbor table: random and directed reports, ticks and reads.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          SLOTS         = 16;
	localparam int          ID_POOL       = 20;
	localparam int          SETTLE_CYCLES = 24;
	localparam int unsigned CYCLE_LIMIT   = 800000;

	typedef struct {
		ntwa_pkg::cmd_t cmd;
		int unsigned    gap;
	} beat_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_write = 1'b0;
	logic               cfg_index = 1'b0;
	logic [15:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         mode = '0;
	logic [15:0]        record_id = '0;
	logic signed [15:0] record_temp = '0;
	logic [15:0]        record_seq = '0;
	logic               sender_is_origin = 1'b0;
	logic [3:0]         read_slot = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [3:0]         slot_used;
	logic               accepted;
	logic               fresh_from_sender;
	logic [3:0]         cleared_count;
	logic [15:0]        out_id;
	logic signed [15:0] out_temp;
	logic [15:0]        out_seq;

	neighbor_table_with_aging #(
		.TABLE_SLOTS(SLOTS)
	) u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.mode             (mode),
		.record_id        (record_id),
		.record_temp      (record_temp),
		.record_seq       (record_seq),
		.sender_is_origin (sender_is_origin),
		.read_slot        (read_slot),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.slot_used        (slot_used),
		.accepted         (accepted),
		.fresh_from_sender(fresh_from_sender),
		.cleared_count    (cleared_count),
		.out_id           (out_id),
		.out_temp         (out_temp),
		.out_seq          (out_seq)
	);

	logic [15:0]        nb_id   [SLOTS];
	logic signed [15:0] nb_temp [SLOTS];
	logic [15:0]        nb_seq  [SLOTS];
	logic [10:0]        nb_age  [SLOTS];
	int unsigned        nb_fill;
	logic [15:0]        cur_own_id;
	logic [10:0]        cur_age_limit;

	beat_t          queued_cmds[$];
	ntwa_pkg::res_t awaited_replies[$];
	int             pushed_cnt = 0;
	int             checked_cnt = 0;
	int             mismatch_cnt = 0;
	int unsigned    cycle_cnt = 0;
	int unsigned    gap_count = 0;
	int unsigned    rx_wait = 0;
	int unsigned    tx_cap = 0;
	int unsigned    rx_cap = 0;
	logic           rx_hold = 1'b0;
	logic           in_took = 1'b0;
	logic           out_took = 1'b0;
	logic [15:0]    id_pool  [ID_POOL];
	logic [15:0]    seq_last [ID_POOL];

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int unsigned idle_draw(input int unsigned cap);
		if (cap == 0 || $urandom_range(2, 0) == 0)
			return 0;
		return $urandom_range(cap, 0);
	endfunction

	function automatic ntwa_pkg::res_t table_reply(input ntwa_pkg::cmd_t c);
		ntwa_pkg::res_t r;
		int unsigned    s, i, cleared;
		logic           hit, take;
		r = '0;
		s = 0;
		hit = 1'b0;
		take = 1'b0;
		cleared = 0;
		case (c.op)
			ntwa_pkg::MODE_REPORT: begin
				for (i = 0; i < nb_fill; i++) begin
					if (!hit && (nb_id[i] == c.id || nb_id[i] == 16'd0)) begin
						hit = 1'b1;
						s = i;
					end
				end
				if (!hit && nb_fill < SLOTS) begin
					s = nb_fill;
					nb_fill++;
					hit = 1'b1;
				end
				if (hit)
					take = c.origin || (s != 0 && (c.seq > nb_seq[s] ||
						(c.seq < ntwa_pkg::WRAP_LOW && nb_seq[s] > ntwa_pkg::WRAP_HIGH)));
				if (take) begin
					nb_id[s]   = c.id;
					nb_temp[s] = c.temp;
					nb_seq[s]  = c.seq;
					nb_age[s]  = '0;
				end
				r.slot_used         = 4'(s);
				r.accepted          = take;
				r.fresh_from_sender = take && c.origin;
			end
			ntwa_pkg::MODE_TICK: begin
				for (i = 1; i < nb_fill; i++) begin
					if (nb_age[i] >= cur_age_limit) begin
						nb_age[i] = '0;
						nb_seq[i] = '0;
						nb_id[i]  = '0;
						if (cleared < ntwa_pkg::CLEARED_MAX)
							cleared++;
					end else begin
						nb_age[i] = nb_age[i] + 11'd1;
					end
				end
				r.cleared_count = 4'(cleared);
			end
			ntwa_pkg::MODE_READ: begin
				if (c.read_slot < SLOTS) begin
					r.out_id   = nb_id[c.read_slot];
					r.out_temp = nb_temp[c.read_slot];
					r.out_seq  = nb_seq[c.read_slot];
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic offer(input logic [1:0] op, input logic [15:0] id,
			input logic signed [15:0] temp, input logic [15:0] seq,
			input logic origin, input logic [3:0] slot);
		beat_t b;
		b.cmd.op        = op;
		b.cmd.id        = id;
		b.cmd.temp      = temp;
		b.cmd.seq       = seq;
		b.cmd.origin    = origin;
		b.cmd.read_slot = slot;
		b.gap           = idle_draw(tx_cap);
		queued_cmds.push_back(b);
		pushed_cnt++;
	endtask

	task automatic push_random(input int n);
		int          k, p;
		int unsigned roll;
		logic [1:0]  op;
		logic [15:0] id;
		for (k = 0; k < n; k++) begin
			roll = $urandom_range(99, 0);
			op = (roll < 58) ? ntwa_pkg::MODE_REPORT : (roll < 75) ? ntwa_pkg::MODE_TICK :
				(roll < 96) ? ntwa_pkg::MODE_READ : ntwa_pkg::OP_NONE;
			p = $urandom_range(ID_POOL - 1, 0);
			roll = $urandom_range(99, 0);
			id = (roll < 80) ? id_pool[p] : (roll < 88) ? cur_own_id : 16'($urandom);
			roll = $urandom_range(99, 0);
			if (roll < 70)
				seq_last[p] = seq_last[p] + 16'($urandom_range(3, 0));
			else if (roll < 80)
				seq_last[p] = $urandom_range(1, 0) ? 16'($urandom_range(65535, 65001)) :
					16'($urandom_range(499, 0));
			else
				seq_last[p] = 16'($urandom);
			offer(op, id, 16'($urandom), seq_last[p], $urandom_range(4, 0) == 0,
				4'($urandom));
		end
	endtask

	task automatic settle();
		while (checked_cnt < pushed_cnt)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_write = 1'b0;
		if (idx == ntwa_pkg::CFG_OWN_ID) begin
			cur_own_id = val;
			nb_id[0]   = val;
		end else begin
			cur_age_limit = val[10:0];
		end
	endtask

	task automatic retune(input logic [15:0] own, input logic [10:0] lim);
		settle();
		write_reg(ntwa_pkg::CFG_OWN_ID, own);
		write_reg(ntwa_pkg::CFG_AGE_LIMIT, {5'd0, lim});
	endtask

	// sender: hold a stalled beat, else present the next one after its gap
	always @(negedge clk) begin : sender
		beat_t nxt;
		logic  hold_beat;
		if (arst_n) begin
			hold_beat = in_valid && !in_took;
			if (!hold_beat && queued_cmds.size() != 0 && gap_count >= queued_cmds[0].gap) begin
				nxt = queued_cmds.pop_front();
				mode             <= nxt.cmd.op;
				record_id        <= nxt.cmd.id;
				record_temp      <= nxt.cmd.temp;
				record_seq       <= nxt.cmd.seq;
				sender_is_origin <= nxt.cmd.origin;
				read_slot        <= nxt.cmd.read_slot;
				in_valid         <= 1'b1;
				gap_count = 0;
			end else if (!hold_beat) begin
				in_valid <= 1'b0;
				if (queued_cmds.size() != 0)
					gap_count++;
			end
		end
	end

	always @(negedge clk) begin : receiver
		if (out_took)
			rx_wait = idle_draw(rx_cap);
		out_stall <= rx_hold || (rx_wait != 0);
		if (rx_wait != 0)
			rx_wait--;
	end

	always @(posedge clk) begin : monitor
		ntwa_pkg::res_t got, want;
		ntwa_pkg::cmd_t seen;
		if (arst_n) begin
			in_took  <= in_valid && !in_stall;
			out_took <= out_valid && !out_stall;
			if (out_valid && !out_stall) begin
				got.slot_used         = slot_used;
				got.accepted          = accepted;
				got.fresh_from_sender = fresh_from_sender;
				got.cleared_count     = cleared_count;
				got.out_id            = out_id;
				got.out_temp          = out_temp;
				got.out_seq           = out_seq;
				if (awaited_replies.size() == 0) begin
					if (mismatch_cnt < 10)
						$display("%0t: result beat with nothing awaited", $realtime);
					mismatch_cnt++;
				end else begin
					want = awaited_replies.pop_front();
					checked_cnt++;
					if (got.slot_used !== want.slot_used || got.accepted !== want.accepted ||
							got.fresh_from_sender !== want.fresh_from_sender ||
							got.cleared_count !== want.cleared_count ||
							got.out_id !== want.out_id || got.out_temp !== want.out_temp ||
							got.out_seq !== want.out_seq) begin
						if (mismatch_cnt < 10)
							$display({"%0t: beat %0d expected slot %0d acc %b fresh %b clr %0d ",
								"id %h temp %0d seq %h, got slot %0d acc %b fresh %b clr %0d ",
								"id %h temp %0d seq %h"}, $realtime, checked_cnt,
								want.slot_used, want.accepted, want.fresh_from_sender,
								want.cleared_count, want.out_id, want.out_temp, want.out_seq,
								got.slot_used, got.accepted, got.fresh_from_sender,
								got.cleared_count, got.out_id, got.out_temp, got.out_seq);
						mismatch_cnt++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				seen.op        = mode;
				seen.id        = record_id;
				seen.temp      = record_temp;
				seen.seq       = record_seq;
				seen.origin    = sender_is_origin;
				seen.read_slot = read_slot;
				awaited_replies.push_back(table_reply(seen));
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin : stimulus
		int i;
		cur_own_id    = ntwa_pkg::OWN_ID_RESET;
		cur_age_limit = ntwa_pkg::AGE_LIMIT_RESET;
		for (i = 0; i < SLOTS; i++) begin
			nb_id[i]   = '0;
			nb_temp[i] = '0;
			nb_seq[i]  = '0;
			nb_age[i]  = '0;
		end
		nb_id[0] = ntwa_pkg::OWN_ID_RESET;
		nb_fill  = 1;
		for (i = 0; i < ID_POOL; i++) begin
			id_pool[i]  = 16'($urandom);
			seq_last[i] = 16'($urandom);
		end
		id_pool[0] = 16'd0;
		id_pool[1] = 16'hFFFF;
		id_pool[2] = 16'd1;

		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		tx_cap = 6;
		rx_cap = 6;
		offer(ntwa_pkg::MODE_READ, 16'd0, 16'sd0, 16'd0, 1'b0, 4'd0);
		offer(ntwa_pkg::MODE_READ, 16'd0, 16'sd0, 16'd0, 1'b0, 4'hF);
		offer(ntwa_pkg::MODE_REPORT, ntwa_pkg::OWN_ID_RESET, 16'sd100, 16'd5, 1'b0, 4'd0);
		offer(ntwa_pkg::MODE_REPORT, ntwa_pkg::OWN_ID_RESET, 16'sd2500, 16'd9, 1'b1, 4'd0);
		offer(ntwa_pkg::MODE_REPORT, 16'd1, -16'sd32768, 16'd10, 1'b0, 4'd0);
		offer(ntwa_pkg::MODE_REPORT, 16'd1, 16'sd7, 16'd10, 1'b0, 4'd0);
		offer(ntwa_pkg::MODE_REPORT, 16'd1, 16'sd32767, 16'd65000, 1'b0, 4'd0);
		offer(ntwa_pkg::MODE_REPORT, 16'd1, 16'sd8, 16'd0, 1'b0, 4'd0);
		offer(ntwa_pkg::MODE_REPORT, 16'd1, 16'sd9, 16'd65001, 1'b0, 4'd0);
		offer(ntwa_pkg::MODE_REPORT, 16'd1, 16'sd10, 16'd500, 1'b0, 4'd0);
		offer(ntwa_pkg::MODE_REPORT, 16'd1, 16'sd11, 16'd499, 1'b0, 4'd0);
		offer(ntwa_pkg::MODE_REPORT, 16'd2, 16'sd12, 16'd0, 1'b0, 4'd0);
		offer(ntwa_pkg::MODE_REPORT, 16'd3, 16'sd13, 16'd7, 1'b0, 4'd0);
		offer(ntwa_pkg::MODE_REPORT, 16'hFFFF, -16'sd1, 16'd0, 1'b1, 4'd0);
		offer(ntwa_pkg::MODE_REPORT, 16'd0, 16'sd14, 16'hFFFF, 1'b0, 4'd0);
		offer(ntwa_pkg::MODE_READ, 16'd0, 16'sd0, 16'd0, 1'b0, 4'd4);
		offer(ntwa_pkg::MODE_READ, 16'd0, 16'sd0, 16'd0, 1'b0, 4'd1);
		offer(ntwa_pkg::MODE_TICK, 16'd0, 16'sd0, 16'd0, 1'b0, 4'd0);
		offer(ntwa_pkg::OP_NONE, 16'hFFFF, -16'sd1, 16'hFFFF, 1'b1, 4'hF);
		offer(ntwa_pkg::MODE_REPORT, 16'd1, 16'sd15, 16'd3, 1'b1, 4'd0);

		retune(16'd1, 11'd1);
		offer(ntwa_pkg::MODE_TICK, 16'd0, 16'sd0, 16'd0, 1'b0, 4'd0);
		offer(ntwa_pkg::MODE_TICK, 16'd0, 16'sd0, 16'd0, 1'b0, 4'd0);
		offer(ntwa_pkg::MODE_READ, 16'd0, 16'sd0, 16'd0, 1'b0, 4'd1);
		offer(ntwa_pkg::MODE_REPORT, 16'd1, 16'sd16, 16'd40, 1'b0, 4'd0);
		offer(ntwa_pkg::MODE_REPORT, 16'd1, 16'sd17, 16'd41, 1'b1, 4'd0);
		offer(ntwa_pkg::MODE_READ, 16'd0, 16'sd0, 16'd0, 1'b0, 4'd0);
		tx_cap = 0;
		rx_cap = 0;
		push_random(300);

		retune(16'hFFFF, 11'd5);
		tx_cap = 18;
		rx_cap = 18;
		push_random(450);
		fork
			begin
				@(posedge clk);
				rx_hold = 1'b1;
				repeat (300) @(posedge clk);
				rx_hold = 1'b0;
			end
		join_none
		settle();
		rx_cap = 0;
		push_random(150);

		retune(16'h1234, 11'd2047);
		tx_cap = 18;
		rx_cap = 0;
		push_random(250);

		retune(ntwa_pkg::OWN_ID_RESET, 11'd40);
		tx_cap = 0;
		rx_cap = 18;
		push_random(350);

		retune(16'($urandom_range(65535, 1)), 11'd3);
		tx_cap = 12;
		rx_cap = 12;
		push_random(400);

		settle();
		if (mismatch_cnt == 0 && awaited_replies.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

@@ neighbor_table_with_aging.f @@
rtl/ntwa_pkg.sv
rtl/ntwa_front.sv
rtl/ntwa_queue.sv
rtl/ntwa_back.sv
rtl/neighbor_table_with_aging.sv
tb/tb_top.sv
